// ===== src/mbet_pkg.sv =====
// Shared types, constants and fixed-point helpers for the Mandelbrot escape-time core.
package mbet_pkg;

  // Format and limits
  localparam int FRAC_BITS       = 28;
  localparam int MAX_DIM         = 4096;
  localparam int ITERATION_LIMIT = 255;

  localparam int FX_W      = 64;
  localparam int HALF_W    = FX_W / 2;
  localparam int ACC_W     = 2 * FX_W;
  localparam int DIM_W     = 13;
  localparam int PIX_W     = 12;
  localparam int SHADE_W   = 8;
  localparam int CFG_IDX_W = 1;

  // Coordinate numerators: (2x + h - w) * 2 and 4y, both below 2^15 in magnitude
  localparam int NUM_W     = 16;
  localparam int MAG_W     = NUM_W - 1;
  localparam int QUO_W     = MAG_W + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(QUO_W + 1);

  typedef logic signed [FX_W-1:0] fx_t;

  localparam fx_t FX_MAX = {1'b0, {(FX_W-1){1'b1}}};
  localparam logic [FX_W-2:0] FX_MAG_MAX = {(FX_W-1){1'b1}};
  localparam logic signed [FX_W:0] SUM_MAX = {2'b00, {(FX_W-1){1'b1}}};
  localparam logic signed [FX_W:0] SUM_MIN = -SUM_MAX;
  localparam fx_t FX_FOUR     = fx_t'(64'd4 << FRAC_BITS);
  localparam fx_t FX_NEG_TWO  = -fx_t'(64'd2 << FRAC_BITS);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  // Coordinate select for the divider
  localparam logic COORD_RE = 1'b0;
  localparam logic COORD_IM = 1'b1;

  // Product select for the multiplier
  localparam logic [1:0] MSEL_RR = 2'd0;
  localparam logic [1:0] MSEL_II = 2'd1;
  localparam logic [1:0] MSEL_RI = 2'd2;

  typedef struct packed {
    logic       load;
    logic       div_start;
    logic       div_sel;
    logic       coord_ld;
    logic       iter_clr;
    logic       upd1;
    logic       upd2;
    logic       mul_start;
    logic [1:0] mul_sel;
    logic       mul_store;
    logic       shade_inc;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic mul_done;
    logic escape;
    logic last_iter;
  } sts_t;

  // Saturating add to the symmetric range
  function automatic fx_t fx_add(fx_t a, fx_t b);
    logic signed [FX_W:0] s;
    s = {a[FX_W-1], a} + {b[FX_W-1], b};
    if (s > SUM_MAX) begin
      return FX_MAX;
    end else if (s < SUM_MIN) begin
      return -FX_MAX;
    end
    return s[FX_W-1:0];
  endfunction

  function automatic fx_t fx_sign(logic [FX_W-2:0] mag, logic neg);
    fx_t m;
    m = {1'b0, mag};
    return neg ? -m : m;
  endfunction

endpackage

// ===== src/mandelbrot_escape_time_pixel_core.sv =====
// Top level of the Mandelbrot escape-time pixel core.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall    in_pixel_x[11:0], in_pixel_y[11:0]
//   out      output     out_valid / out_stall  out_shade[7:0]
//   cfg      input      cfg_wr_en              cfg_index[0], cfg_wdata[12:0]
//
// One request at a time. Mapping to c takes two serial divisions, one per coordinate.
// Each iteration then runs three 64x64 products on a single 32x32 multiplier, two
// update steps and one escape test; the first skips the cross product.
// The result register lets a new request in while out_stall holds the last one.
// Synchronous active-low reset clears control; configuration returns to 1920x1080.
module mandelbrot_escape_time_pixel_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [mbet_pkg::PIX_W-1:0]      in_pixel_x,
  input  logic [mbet_pkg::PIX_W-1:0]      in_pixel_y,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mbet_pkg::SHADE_W-1:0]    out_shade,
  input  logic                            cfg_wr_en,
  input  logic [mbet_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbet_pkg::DIM_W-1:0]      cfg_wdata
);

  mbet_pkg::cmd_t cmd;
  mbet_pkg::sts_t sts;

  mbet_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mbet_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_pixel_x (in_pixel_x),
    .in_pixel_y (in_pixel_y),
    .out_shade  (out_shade)
  );

endmodule

// ===== src/mbet_div.sv =====
// Restoring divider, one quotient bit per cycle, for the pixel-to-plane mapping.
module mbet_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [mbet_pkg::MAG_W-1:0]  num_mag,
  input  logic [mbet_pkg::DIM_W-1:0]  den,
  output logic                        done,
  output logic [mbet_pkg::QUO_W-1:0]  quot
);

  logic [mbet_pkg::DIM_W-1:0]     den_r;
  logic [mbet_pkg::DIM_W-1:0]     rem_r;
  logic [mbet_pkg::QUO_W-1:0]     quo_r;
  logic [mbet_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                           busy_r;
  logic                           done_r;

  logic [mbet_pkg::DIM_W:0] trial;
  logic [mbet_pkg::DIM_W:0] diff;
  logic                     ge;

  assign trial = {rem_r, quo_r[mbet_pkg::QUO_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        // dividend is the magnitude scaled up by the fraction bits
        quo_r  <= mbet_pkg::QUO_W'(num_mag) << mbet_pkg::FRAC_BITS;
        rem_r  <= '0;
        den_r  <= den;
        cnt_r  <= mbet_pkg::DIV_CNT_W'(mbet_pkg::QUO_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? diff[mbet_pkg::DIM_W-1:0] : trial[mbet_pkg::DIM_W-1:0];
        quo_r <= {quo_r[mbet_pkg::QUO_W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == mbet_pkg::DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

// ===== src/mbet_mul.sv =====
// Saturating fixed-point multiplier: four 32x32 partial products on one multiplier.
module mbet_mul (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  mbet_pkg::fx_t   a,
  input  mbet_pkg::fx_t   b,
  output logic            done,
  output mbet_pkg::fx_t   prod
);

  localparam logic [2:0] LAST_PP = 3'd3;
  localparam logic [2:0] FIN_CNT = 3'd5;

  logic [mbet_pkg::FX_W-1:0]  ua_r;
  logic [mbet_pkg::FX_W-1:0]  ub_r;
  logic                       neg_r;
  logic [mbet_pkg::FX_W-1:0]  pp_r;
  logic [1:0]                 col_r;
  logic [mbet_pkg::ACC_W-1:0] acc_r;
  logic [2:0]                 cnt_r;
  logic                       busy_r;
  logic                       done_r;
  mbet_pkg::fx_t              prod_r;

  logic [mbet_pkg::FX_W-1:0]   ua;
  logic [mbet_pkg::FX_W-1:0]   ub;
  logic [1:0]                  k;
  logic [mbet_pkg::HALF_W-1:0] a_half;
  logic [mbet_pkg::HALF_W-1:0] b_half;
  logic [mbet_pkg::FX_W-1:0]   pp;
  logic [1:0]                  col;
  logic [mbet_pkg::ACC_W-1:0]  pp_shift;
  logic                        sat;
  logic [mbet_pkg::FX_W-2:0]   mag;

  assign ua = a[mbet_pkg::FX_W-1] ? $unsigned(-a) : $unsigned(a);
  assign ub = b[mbet_pkg::FX_W-1] ? $unsigned(-b) : $unsigned(b);

  // step order: lo*lo, lo*hi, hi*lo, hi*hi
  assign k      = cnt_r[1:0];
  assign a_half = k[1] ? ua_r[mbet_pkg::FX_W-1:mbet_pkg::HALF_W] : ua_r[mbet_pkg::HALF_W-1:0];
  assign b_half = k[0] ? ub_r[mbet_pkg::FX_W-1:mbet_pkg::HALF_W] : ub_r[mbet_pkg::HALF_W-1:0];
  assign pp     = a_half * b_half;
  assign col    = {1'b0, k[1]} + {1'b0, k[0]};

  always_comb begin
    case (col_r)
      2'd0:    pp_shift = {{mbet_pkg::FX_W{1'b0}}, pp_r};
      2'd1:    pp_shift = {{mbet_pkg::HALF_W{1'b0}}, pp_r, {mbet_pkg::HALF_W{1'b0}}};
      2'd2:    pp_shift = {pp_r, {mbet_pkg::FX_W{1'b0}}};
      default: pp_shift = '0;
    endcase
  end

  assign sat = |acc_r[mbet_pkg::ACC_W-1:mbet_pkg::FX_W-1+mbet_pkg::FRAC_BITS];
  assign mag = sat ? mbet_pkg::FX_MAG_MAX
                   : acc_r[mbet_pkg::FX_W-2+mbet_pkg::FRAC_BITS:mbet_pkg::FRAC_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        ua_r   <= ua;
        ub_r   <= ub;
        neg_r  <= a[mbet_pkg::FX_W-1] ^ b[mbet_pkg::FX_W-1];
        acc_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (cnt_r <= LAST_PP) begin
          pp_r  <= pp;
          col_r <= col;
        end
        if (cnt_r != 3'd0 && cnt_r <= LAST_PP + 3'd1) begin
          acc_r <= acc_r + pp_shift;
        end
        if (cnt_r == FIN_CNT) begin
          prod_r <= mbet_pkg::fx_sign(mag, neg_r);
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 3'd1;
      end
    end
  end

  assign done = done_r;
  assign prod = prod_r;

endmodule

// ===== src/mbet_dp.sv =====
// Datapath: configuration, coordinate mapping, z iteration registers and shade counter.
module mbet_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mbet_pkg::cmd_t                  cmd,
  output mbet_pkg::sts_t                  sts,
  input  logic                            cfg_wr_en,
  input  logic [mbet_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbet_pkg::DIM_W-1:0]      cfg_wdata,
  input  logic [mbet_pkg::PIX_W-1:0]      in_pixel_x,
  input  logic [mbet_pkg::PIX_W-1:0]      in_pixel_y,
  output logic [mbet_pkg::SHADE_W-1:0]    out_shade
);

  logic [mbet_pkg::DIM_W-1:0]   width_r;
  logic [mbet_pkg::DIM_W-1:0]   height_r;
  logic [mbet_pkg::DIM_W-1:0]   den_r;
  logic [mbet_pkg::MAG_W-1:0]   num_mag_r;
  logic                         num_neg_r;
  logic [mbet_pkg::MAG_W-1:0]   numi_mag_r;
  mbet_pkg::fx_t                cr_r, ci_r, zr_r, zi_r, sr_r, si_r, xy_r, tr_r, ti_r;
  logic [mbet_pkg::SHADE_W-1:0] shade_r;
  logic [mbet_pkg::SHADE_W-1:0] out_shade_r;

  logic [mbet_pkg::DIM_W-1:0]   w_c;
  logic [mbet_pkg::DIM_W-1:0]   h_lim;
  logic [mbet_pkg::DIM_W-1:0]   h_c;
  logic [mbet_pkg::NUM_W-1:0]   half_num;
  logic [mbet_pkg::NUM_W-1:0]   num;
  logic [mbet_pkg::NUM_W-1:0]   num_abs;
  logic [mbet_pkg::MAG_W-1:0]   div_num;
  logic                         div_done;
  logic [mbet_pkg::QUO_W-1:0]   div_quot;
  logic [mbet_pkg::ACC_W-1:0]   q_ext;
  logic [mbet_pkg::FX_W-2:0]    c_mag;
  logic                         c_neg;
  mbet_pkg::fx_t                c_val;
  mbet_pkg::fx_t                mul_a, mul_b, mul_prod;
  logic                         mul_done;

  // clamp dimensions; zero height behaves as one
  assign w_c   = (32'(width_r) > mbet_pkg::MAX_DIM) ?
                 mbet_pkg::DIM_W'(mbet_pkg::MAX_DIM) : width_r;
  assign h_lim = (32'(height_r) > mbet_pkg::MAX_DIM) ?
                 mbet_pkg::DIM_W'(mbet_pkg::MAX_DIM) : height_r;
  assign h_c   = (h_lim == '0) ? mbet_pkg::DIM_W'(1) : h_lim;

  assign half_num = {{(mbet_pkg::NUM_W-mbet_pkg::PIX_W-1){1'b0}}, in_pixel_x, 1'b0}
                  + mbet_pkg::NUM_W'(h_c) - mbet_pkg::NUM_W'(w_c);
  assign num      = {half_num[mbet_pkg::NUM_W-2:0], 1'b0};
  assign num_abs  = num[mbet_pkg::NUM_W-1] ? (~num + 1'b1) : num;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= mbet_pkg::DIM_W'(1920);
      height_r <= mbet_pkg::DIM_W'(1080);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        mbet_pkg::REG_WIDTH:  width_r  <= cfg_wdata;
        mbet_pkg::REG_HEIGHT: height_r <= cfg_wdata;
      endcase
    end
  end

  assign div_num = (cmd.div_sel == mbet_pkg::COORD_IM) ? numi_mag_r : num_mag_r;

  mbet_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .num_mag (div_num),
    .den     (den_r),
    .done    (div_done),
    .quot    (div_quot)
  );

  // saturate, sign, then shift the plane down by two
  assign q_ext = mbet_pkg::ACC_W'(div_quot);
  assign c_mag = (|q_ext[mbet_pkg::ACC_W-1:mbet_pkg::FX_W-1]) ? mbet_pkg::FX_MAG_MAX
                                                               : q_ext[mbet_pkg::FX_W-2:0];
  assign c_neg = (cmd.div_sel == mbet_pkg::COORD_RE) ? num_neg_r : 1'b0;
  assign c_val = mbet_pkg::fx_add(mbet_pkg::fx_sign(c_mag, c_neg), mbet_pkg::FX_NEG_TWO);

  always_comb begin
    case (cmd.mul_sel)
      mbet_pkg::MSEL_II: begin
        mul_a = zi_r;
        mul_b = zi_r;
      end
      mbet_pkg::MSEL_RI: begin
        mul_a = zr_r;
        mul_b = zi_r;
      end
      default: begin
        mul_a = zr_r;
        mul_b = zr_r;
      end
    endcase
  end

  mbet_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      den_r      <= h_c;
      num_mag_r  <= num_abs[mbet_pkg::MAG_W-1:0];
      num_neg_r  <= num[mbet_pkg::NUM_W-1];
      numi_mag_r <= mbet_pkg::MAG_W'({in_pixel_y, 2'b00});
    end
    if (cmd.coord_ld) begin
      if (cmd.div_sel == mbet_pkg::COORD_IM) begin
        ci_r <= c_val;
      end else begin
        cr_r <= c_val;
      end
    end
    if (cmd.iter_clr) begin
      zr_r    <= '0;
      zi_r    <= '0;
      sr_r    <= '0;
      si_r    <= '0;
      xy_r    <= '0;
      shade_r <= '0;
    end
    if (cmd.upd1) begin
      tr_r <= mbet_pkg::fx_add(sr_r, -si_r);
      ti_r <= mbet_pkg::fx_add(xy_r, xy_r);
    end
    if (cmd.upd2) begin
      zr_r <= mbet_pkg::fx_add(tr_r, cr_r);
      zi_r <= mbet_pkg::fx_add(ti_r, ci_r);
    end
    if (cmd.mul_store) begin
      case (cmd.mul_sel)
        mbet_pkg::MSEL_RR: sr_r <= mul_prod;
        mbet_pkg::MSEL_II: si_r <= mul_prod;
        mbet_pkg::MSEL_RI: xy_r <= mul_prod;
        default: ;
      endcase
    end
    if (cmd.shade_inc) begin
      shade_r <= shade_r + 1'b1;
    end
    if (cmd.out_load) begin
      out_shade_r <= shade_r;
    end
  end

  assign sts.div_done  = div_done;
  assign sts.mul_done  = mul_done;
  assign sts.escape    = mbet_pkg::fx_add(sr_r, si_r) > mbet_pkg::FX_FOUR;
  assign sts.last_iter = shade_r == mbet_pkg::SHADE_W'(mbet_pkg::ITERATION_LIMIT - 1);

  assign out_shade = out_shade_r;

endmodule

// ===== src/mbet_ctrl.sv =====
// Controller: sequences mapping, iteration steps and result hand-off.
module mbet_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  mbet_pkg::sts_t sts,
  output mbet_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DIV_GO   = 4'd1;
  localparam logic [3:0] S_DIV_WAIT = 4'd2;
  localparam logic [3:0] S_UPD1     = 4'd3;
  localparam logic [3:0] S_UPD2     = 4'd4;
  localparam logic [3:0] S_MUL_GO   = 4'd5;
  localparam logic [3:0] S_MUL_WAIT = 4'd6;
  localparam logic [3:0] S_TEST     = 4'd7;
  localparam logic [3:0] S_FIN      = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       div_sel_r, div_sel_nxt;
  logic [1:0] mul_sel_r, mul_sel_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    div_sel_nxt   = div_sel_r;
    mul_sel_nxt   = mul_sel_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.div_sel   = div_sel_r;
    cmd.mul_sel   = mul_sel_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load    = 1'b1;
          div_sel_nxt = mbet_pkg::COORD_RE;
          state_nxt   = S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (sts.div_done) begin
          cmd.coord_ld = 1'b1;
          if (div_sel_r == mbet_pkg::COORD_RE) begin
            div_sel_nxt = mbet_pkg::COORD_IM;
            state_nxt   = S_DIV_GO;
          end else begin
            cmd.iter_clr = 1'b1;
            state_nxt    = S_UPD1;
          end
        end
      end
      S_UPD1: begin
        cmd.upd1  = 1'b1;
        state_nxt = S_UPD2;
      end
      S_UPD2: begin
        cmd.upd2    = 1'b1;
        mul_sel_nxt = mbet_pkg::MSEL_RR;
        state_nxt   = S_MUL_GO;
      end
      S_MUL_GO: begin
        cmd.mul_start = 1'b1;
        state_nxt     = S_MUL_WAIT;
      end
      S_MUL_WAIT: begin
        if (sts.mul_done) begin
          cmd.mul_store = 1'b1;
          if (mul_sel_r == mbet_pkg::MSEL_RR) begin
            mul_sel_nxt = mbet_pkg::MSEL_II;
            state_nxt   = S_MUL_GO;
          end else if (mul_sel_r == mbet_pkg::MSEL_II) begin
            state_nxt = S_TEST;
          end else begin
            state_nxt = S_UPD1;
          end
        end
      end
      S_TEST: begin
        // squares of the new z are in place: test |z|^2 > 4
        if (sts.escape) begin
          state_nxt = S_FIN;
        end else begin
          cmd.shade_inc = 1'b1;
          if (sts.last_iter) begin
            state_nxt = S_FIN;
          end else begin
            mul_sel_nxt = mbet_pkg::MSEL_RI;
            state_nxt   = S_MUL_GO;
          end
        end
      end
      S_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_sel_r   <= mbet_pkg::COORD_RE;
      mul_sel_r   <= mbet_pkg::MSEL_RR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_sel_r   <= div_sel_nxt;
      mul_sel_r   <= mul_sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;

endmodule
